// ----- rtl/sds_pkg.sv -----
// shared constants for the spin drag scale pipeline
`timescale 1ns / 1ps
`default_nettype none
package sds_pkg;

  // fraction bits of the vector and max_spin formats
  localparam int FRAC_BITS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WIND_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIND_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIND_Z        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REDUCTION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PENALTY   = 3'd5;

  // square root unit: radicand and root widths
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;

  // divider: divisor width, quotient bits, numerator width
  localparam int DEN_W = 31;
  localparam int QUO_W = 17;
  localparam int NUM_W = DEN_W + QUO_W;

  // one in q.16
  localparam logic [17:0] UNIT_ONE = 18'd65536;

endpackage
`default_nettype wire

// ----- rtl/sds_isqrt.sv -----
// pipelined integer square root, one result bit per stage, several lanes
`timescale 1ns / 1ps
`default_nettype none
module sds_isqrt import sds_pkg::*; #(
  parameter int LANES = 3,
  parameter int TW    = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [LANES-1:0][SQ_W-1:0]      in_rad,
  input  logic [TW-1:0]                   in_tag,
  output logic                            out_valid,
  output logic [LANES-1:0][ROOT_W-1:0]    out_root,
  output logic [TW-1:0]                   out_tag
);

  localparam int STEPS = SQ_W / 2;

  logic [STEPS-1:0]                 v_r;
  logic [LANES-1:0][SQ_W-1:0]       rem_r    [STEPS];
  logic [LANES-1:0][SQ_W-1:0]       root_r   [STEPS];
  logic [LANES-1:0][SQ_W-1:0]       rem_nxt  [STEPS];
  logic [LANES-1:0][SQ_W-1:0]       root_nxt [STEPS];
  logic [LANES-1:0][SQ_W-1:0]       rem_src  [STEPS];
  logic [LANES-1:0][SQ_W-1:0]       root_src [STEPS];
  logic [TW-1:0]                    tag_r    [STEPS];

  always_comb begin
    rem_src[0]  = in_rad;
    root_src[0] = '0;
    for (int s = 1; s < STEPS; s++) begin
      rem_src[s]  = rem_r[s-1];
      root_src[s] = root_r[s-1];
    end
  end

  // bit-pair restoring step
  always_comb begin
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] trial;
    for (int s = 0; s < STEPS; s++) begin
      bitv = SQ_W'(1) << (SQ_W - 2 - 2 * s);
      for (int l = 0; l < LANES; l++) begin
        trial = root_src[s][l] + bitv;
        if (rem_src[s][l] >= trial) begin
          rem_nxt[s][l]  = rem_src[s][l] - trial;
          root_nxt[s][l] = (root_src[s][l] >> 1) + bitv;
        end else begin
          rem_nxt[s][l]  = rem_src[s][l];
          root_nxt[s][l] = root_src[s][l] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    for (int s = 0; s < STEPS; s++) begin
      rem_r[s]  <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
    end
    for (int s = 1; s < STEPS; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_root[l] = root_r[STEPS-1][l][ROOT_W-1:0];
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_tag   = tag_r[STEPS-1];

endmodule
`default_nettype wire

// ----- rtl/sds_div.sv -----
// pipelined restoring divider, one quotient bit per stage, several lanes
`timescale 1ns / 1ps
`default_nettype none
module sds_div import sds_pkg::*; #(
  parameter int LANES = 7,
  parameter int TW    = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]   in_num,
  input  logic [LANES-1:0][DEN_W-1:0]   in_den,
  input  logic [TW-1:0]                 in_tag,
  output logic                          out_valid,
  output logic [LANES-1:0][QUO_W-1:0]   out_quo,
  output logic [TW-1:0]                 out_tag
);

  logic [QUO_W-1:0]                 v_r;
  logic [LANES-1:0][NUM_W-1:0]      rem_r   [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]      den_r   [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]      quo_r   [QUO_W];
  logic [LANES-1:0][NUM_W-1:0]      rem_nxt [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]      quo_nxt [QUO_W];
  logic [LANES-1:0][NUM_W-1:0]      rem_src [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]      den_src [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]      quo_src [QUO_W];
  logic [TW-1:0]                    tag_r   [QUO_W];

  always_comb begin
    rem_src[0] = in_num;
    den_src[0] = in_den;
    quo_src[0] = '0;
    for (int s = 1; s < QUO_W; s++) begin
      rem_src[s] = rem_r[s-1];
      den_src[s] = den_r[s-1];
      quo_src[s] = quo_r[s-1];
    end
  end

  // msb first
  always_comb begin
    logic [NUM_W-1:0] sub;
    for (int s = 0; s < QUO_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        sub = NUM_W'(den_src[s][l]) << (QUO_W - 1 - s);
        if (rem_src[s][l] >= sub) begin
          rem_nxt[s][l] = rem_src[s][l] - sub;
          quo_nxt[s][l] = quo_src[s][l] | (QUO_W'(1) << (QUO_W - 1 - s));
        end else begin
          rem_nxt[s][l] = rem_src[s][l];
          quo_nxt[s][l] = quo_src[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    for (int s = 0; s < QUO_W; s++) begin
      rem_r[s] <= rem_nxt[s];
      den_r[s] <= den_src[s];
      quo_r[s] <= quo_nxt[s];
    end
    for (int s = 1; s < QUO_W; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
  end

  assign out_valid = v_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_tag   = tag_r[QUO_W-1];

endmodule
`default_nettype wire

// ----- rtl/spin_drag_scale.sv -----
// spin drag scale: top level, front end, alignment and output stages
// depth: 59 register stages from the accepting edge of start to out_valid
// throughput: one transaction per cycle, busy is never raised
// depth set by the 32-stage square root unit and the 17-stage divider
// the receiver cannot stall; one result per transaction, strobed by out_valid
// synchronous active-low reset clears valid bits and loads register defaults
`timescale 1ns / 1ps
`default_nettype none
module spin_drag_scale import sds_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  logic [31:0]            in_vel_x,
  input  logic [31:0]            in_vel_y,
  input  logic [31:0]            in_vel_z,
  input  logic [31:0]            in_spin_x,
  input  logic [31:0]            in_spin_y,
  input  logic [31:0]            in_spin_z,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // results
  output logic                   out_valid,
  output logic [17:0]            out_drag_mult,
  output logic                   out_too_slow,
  output logic                   out_was_clamped
);

  // speed threshold, 1e-6 in the squared format
  localparam logic [63:0] THR = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000;

  // side data carried past the square root unit
  typedef struct packed {
    logic             too_slow;
    logic [2:0]       rneg;
    logic [2:0]       wneg;
    logic [2:0][29:0] rsh;
    logic [2:0][29:0] wsh;
  } root_tag_t;

  // side data carried past the divider
  typedef struct packed {
    logic       too_slow;
    logic [2:0] rneg;
    logic [2:0] wneg;
    logic       sf_sat;
  } div_tag_t;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [2:0][31:0] wind_r;
  logic [30:0]      max_spin_r;
  logic [15:0]      max_red_r;
  logic [15:0]      max_pen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wind_r     <= '0;
      max_spin_r <= 31'd3276800;
      max_red_r  <= 16'd19661;
      max_pen_r  <= 16'd9830;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIND_X:        wind_r[0]  <= cfg_data;
        REG_WIND_Y:        wind_r[1]  <= cfg_data;
        REG_WIND_Z:        wind_r[2]  <= cfg_data;
        REG_MAX_SPIN:      max_spin_r <= cfg_data[30:0];
        REG_MAX_REDUCTION: max_red_r  <= cfg_data[15:0];
        REG_MAX_PENALTY:   max_pen_r  <= cfg_data[15:0];
        default:           ;  // unknown index, write dropped
      endcase
    end
  end

  // fully pipelined, never refuses a transaction
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------
  // stage 1: relative velocity, magnitudes and signs
  // ---------------------------------------------------------------
  logic [2:0][31:0] vel, spin;
  assign vel  = {in_vel_z, in_vel_y, in_vel_x};
  assign spin = {in_spin_z, in_spin_y, in_spin_x};

  logic [2:0][32:0] s1_rmag_r, s1_rmag_nxt;
  logic [2:0][31:0] s1_wmag_r, s1_wmag_nxt;
  logic [2:0]       s1_rneg_r, s1_rneg_nxt;
  logic [2:0]       s1_wneg_r;
  logic             s1_big_r,  s1_big_nxt;
  logic             s1_v_r;

  always_comb begin
    logic signed [32:0] rdiff;
    s1_big_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rdiff = $signed({vel[i][31], vel[i]}) - $signed({wind_r[i][31], wind_r[i]});
      s1_rneg_nxt[i] = rdiff[32];
      s1_rmag_nxt[i] = rdiff[32] ? 33'(-rdiff) : 33'(rdiff);
      s1_wmag_nxt[i] = spin[i][31] ? 32'(-spin[i]) : spin[i];
      // magnitude of 2^31 or more: speed test passes outright
      s1_big_nxt = s1_big_nxt | s1_rmag_nxt[i][32] | s1_rmag_nxt[i][31];
    end
  end

  always_ff @(posedge clk) begin
    s1_rmag_r <= s1_rmag_nxt;
    s1_wmag_r <= s1_wmag_nxt;
    s1_rneg_r <= s1_rneg_nxt;
    s1_wneg_r <= {in_spin_z[31], in_spin_y[31], in_spin_x[31]};
    s1_big_r  <= s1_big_nxt;
  end

  // ---------------------------------------------------------------
  // stage 2: component squares and shrink to below 2^30
  // ---------------------------------------------------------------
  logic [2:0][61:0] s2_rsq_r, s2_rsq_nxt;
  logic [2:0][63:0] s2_wsq_r, s2_wsq_nxt;
  logic [2:0][29:0] s2_rsh_r, s2_rsh_nxt;
  logic [2:0][29:0] s2_wsh_r, s2_wsh_nxt;
  logic [2:0]       s2_rneg_r, s2_wneg_r;
  logic             s2_big_r;
  logic             s2_v_r;

  always_comb begin
    logic       rb32, rb31, rb30, wb31, wb30;
    logic [1:0] rk;
    logic       wk;
    rb32 = s1_rmag_r[0][32] | s1_rmag_r[1][32] | s1_rmag_r[2][32];
    rb31 = s1_rmag_r[0][31] | s1_rmag_r[1][31] | s1_rmag_r[2][31];
    rb30 = s1_rmag_r[0][30] | s1_rmag_r[1][30] | s1_rmag_r[2][30];
    wb31 = s1_wmag_r[0][31] | s1_wmag_r[1][31] | s1_wmag_r[2][31];
    wb30 = s1_wmag_r[0][30] | s1_wmag_r[1][30] | s1_wmag_r[2][30];
    // halvings needed, from the top set bit over the vector
    if (rb32)      rk = 2'd3;
    else if (rb31) rk = 2'd2;
    else if (rb30) rk = 2'd1;
    else           rk = 2'd0;
    wk = 1'b0;
    if (wb31 || wb30) wk = 1'b1;
    for (int i = 0; i < 3; i++) begin
      s2_rsq_nxt[i] = s1_rmag_r[i][30:0] * s1_rmag_r[i][30:0];
      s2_wsq_nxt[i] = s1_wmag_r[i] * s1_wmag_r[i];
      s2_rsh_nxt[i] = 30'(s1_rmag_r[i] >> rk);
      if (wb31)
        s2_wsh_nxt[i] = 30'(s1_wmag_r[i] >> 2);
      else
        s2_wsh_nxt[i] = 30'(s1_wmag_r[i] >> wk);
    end
  end

  always_ff @(posedge clk) begin
    s2_rsq_r  <= s2_rsq_nxt;
    s2_wsq_r  <= s2_wsq_nxt;
    s2_rsh_r  <= s2_rsh_nxt;
    s2_wsh_r  <= s2_wsh_nxt;
    s2_rneg_r <= s1_rneg_r;
    s2_wneg_r <= s1_wneg_r;
    s2_big_r  <= s1_big_r;
  end

  // ---------------------------------------------------------------
  // stage 3: threshold test, squares of the shrunk vectors
  // ---------------------------------------------------------------
  logic [63:0]      s3_wsq_r, s3_wsq_nxt;
  logic             s3_slow_r, s3_slow_nxt;
  logic [2:0][59:0] s3_rq_r, s3_rq_nxt;
  logic [2:0][59:0] s3_wq_r, s3_wq_nxt;
  logic [2:0][29:0] s3_rsh_r, s3_wsh_r;
  logic [2:0]       s3_rneg_r, s3_wneg_r;
  logic             s3_v_r;

  always_comb begin
    logic [63:0] vsq;
    vsq        = 64'(s2_rsq_r[0]) + 64'(s2_rsq_r[1]) + 64'(s2_rsq_r[2]);
    s3_wsq_nxt = s2_wsq_r[0] + s2_wsq_r[1] + s2_wsq_r[2];
    s3_slow_nxt = (!s2_big_r && vsq <= THR) || (s3_wsq_nxt <= THR);
    for (int i = 0; i < 3; i++) begin
      s3_rq_nxt[i] = s2_rsh_r[i] * s2_rsh_r[i];
      s3_wq_nxt[i] = s2_wsh_r[i] * s2_wsh_r[i];
    end
  end

  always_ff @(posedge clk) begin
    s3_wsq_r  <= s3_wsq_nxt;
    s3_slow_r <= s3_slow_nxt;
    s3_rq_r   <= s3_rq_nxt;
    s3_wq_r   <= s3_wq_nxt;
    s3_rsh_r  <= s2_rsh_r;
    s3_wsh_r  <= s2_wsh_r;
    s3_rneg_r <= s2_rneg_r;
    s3_wneg_r <= s2_wneg_r;
  end

  // ---------------------------------------------------------------
  // stage 4: sums for the unit vector norms
  // ---------------------------------------------------------------
  logic [63:0] s4_wsq_r;
  logic [61:0] s4_rn_r, s4_wn_r;
  root_tag_t   s4_tag_r;
  logic        s4_v_r;

  always_ff @(posedge clk) begin
    s4_wsq_r          <= s3_wsq_r;
    s4_rn_r           <= 62'(s3_rq_r[0]) + 62'(s3_rq_r[1]) + 62'(s3_rq_r[2]);
    s4_wn_r           <= 62'(s3_wq_r[0]) + 62'(s3_wq_r[1]) + 62'(s3_wq_r[2]);
    s4_tag_r.too_slow <= s3_slow_r;
    s4_tag_r.rneg     <= s3_rneg_r;
    s4_tag_r.wneg     <= s3_wneg_r;
    s4_tag_r.rsh      <= s3_rsh_r;
    s4_tag_r.wsh      <= s3_wsh_r;
  end

  // front-end valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // ---------------------------------------------------------------
  // square roots: spin magnitude, shrunk velocity and spin norms
  // ---------------------------------------------------------------
  logic [2:0][SQ_W-1:0]   rt_rad;
  logic [2:0][ROOT_W-1:0] rt_root;
  root_tag_t              rt_tag;
  logic                   rt_v;

  assign rt_rad = {SQ_W'(s4_wn_r), SQ_W'(s4_rn_r), s4_wsq_r};

  sds_isqrt #(
    .LANES (3),
    .TW    ($bits(root_tag_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_v_r),
    .in_rad    (rt_rad),
    .in_tag    (s4_tag_r),
    .out_valid (rt_v),
    .out_root  (rt_root),
    .out_tag   (rt_tag)
  );

  // ---------------------------------------------------------------
  // divisions: three unit components per vector and the spin factor
  // ---------------------------------------------------------------
  logic [6:0][NUM_W-1:0] dv_num;
  logic [6:0][DEN_W-1:0] dv_den;
  logic [6:0][QUO_W-1:0] dv_quo;
  div_tag_t              dv_tag_in, dv_tag;
  logic                  dv_v;

  always_comb begin
    logic [DEN_W-1:0] rnorm, wnorm;
    rnorm = rt_root[1][DEN_W-1:0];
    wnorm = rt_root[2][DEN_W-1:0];
    if (rnorm == '0) rnorm = DEN_W'(1);
    if (wnorm == '0) wnorm = DEN_W'(1);
    for (int i = 0; i < 3; i++) begin
      dv_num[i]     = NUM_W'({rt_tag.rsh[i], 16'd0});
      dv_den[i]     = rnorm;
      dv_num[i + 3] = NUM_W'({rt_tag.wsh[i], 16'd0});
      dv_den[i + 3] = wnorm;
    end
    dv_num[6]          = NUM_W'({rt_root[0], 16'd0});
    dv_den[6]          = max_spin_r;
    dv_tag_in.too_slow = rt_tag.too_slow;
    dv_tag_in.rneg     = rt_tag.rneg;
    dv_tag_in.wneg     = rt_tag.wneg;
    dv_tag_in.sf_sat   = rt_root[0] >= ROOT_W'(max_spin_r);
  end

  sds_div #(
    .LANES (7),
    .TW    ($bits(div_tag_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rt_v),
    .in_num    (dv_num),
    .in_den    (dv_den),
    .in_tag    (dv_tag_in),
    .out_valid (dv_v),
    .out_quo   (dv_quo),
    .out_tag   (dv_tag)
  );

  // ---------------------------------------------------------------
  // e1: signed unit components, pairwise products, spin factor
  // ---------------------------------------------------------------
  logic [2:0][35:0] e1_prod_r, e1_prod_nxt;
  logic [16:0]      e1_sf_r;
  logic             e1_slow_r;

  always_comb begin
    logic signed [17:0] ur, uw;
    for (int i = 0; i < 3; i++) begin
      ur = dv_tag.rneg[i] ? -$signed({1'b0, dv_quo[i]})     : $signed({1'b0, dv_quo[i]});
      uw = dv_tag.wneg[i] ? -$signed({1'b0, dv_quo[i + 3]}) : $signed({1'b0, dv_quo[i + 3]});
      e1_prod_nxt[i] = 36'(ur * uw);
    end
  end

  always_ff @(posedge clk) begin
    e1_prod_r <= e1_prod_nxt;
    e1_sf_r   <= dv_tag.sf_sat ? UNIT_ONE[16:0] : dv_quo[6];
    e1_slow_r <= dv_tag.too_slow;
  end

  // ---------------------------------------------------------------
  // e2: dot product, scale back to q.16 toward zero, clamp to +-1
  // ---------------------------------------------------------------
  logic signed [17:0] e2_a_r, e2_a_nxt;
  logic [16:0]        e2_sf_r;
  logic               e2_slow_r;

  always_comb begin
    logic signed [37:0] dot, adj, shr;
    dot = 38'($signed(e1_prod_r[0])) + 38'($signed(e1_prod_r[1]))
        + 38'($signed(e1_prod_r[2]));
    adj = dot[37] ? dot + 38'sd65535 : dot;
    shr = adj >>> 16;
    if (shr > 38'sd65536)       e2_a_nxt = 18'sd65536;
    else if (shr < -38'sd65536) e2_a_nxt = -18'sd65536;
    else                        e2_a_nxt = 18'(shr);
  end

  always_ff @(posedge clk) begin
    e2_a_r    <= e2_a_nxt;
    e2_sf_r   <= e1_sf_r;
    e2_slow_r <= e1_slow_r;
  end

  // ---------------------------------------------------------------
  // e3: gain times spin factor, misalignment over three (estimate)
  // ---------------------------------------------------------------
  logic [32:0] e3_redp_r, e3_penp_r;
  logic [16:0] e3_apos_r;
  logic        e3_misneed_r;
  logic [17:0] e3_x_r;
  logic [16:0] e3_q0_r;
  logic        e3_slow_r;
  logic [17:0] e3_x_nxt;
  logic [37:0] e3_xm;

  always_comb begin
    logic signed [19:0] xs;
    xs = (20'sd32768 - 20'(e2_a_r)) <<< 1;
    e3_x_nxt = xs[17:0];
  end

  assign e3_xm = 38'(e3_x_nxt) * 38'd349525;

  always_ff @(posedge clk) begin
    e3_redp_r    <= 33'(max_red_r) * 33'(e2_sf_r);
    e3_penp_r    <= 33'(max_pen_r) * 33'(e2_sf_r);
    e3_apos_r    <= (!e2_a_r[17] && e2_a_r != '0) ? e2_a_r[16:0] : 17'd0;
    e3_misneed_r <= e2_a_r < 18'sd32768;
    e3_x_r       <= e3_x_nxt;
    e3_q0_r      <= e3_xm[36:20];
    e3_slow_r    <= e2_slow_r;
  end

  // ---------------------------------------------------------------
  // e4: correct the quotient, reduction product
  // ---------------------------------------------------------------
  logic [49:0] e4_redf_r;
  logic [32:0] e4_penp_r;
  logic [16:0] e4_mis_r, e4_mis_nxt;
  logic        e4_slow_r;

  always_comb begin
    logic [18:0] rem3;
    rem3 = 19'(e3_x_r) - 19'(e3_q0_r) * 19'd3;
    if (rem3 >= 19'd3) e4_mis_nxt = e3_q0_r + 17'd1;
    else               e4_mis_nxt = e3_q0_r;
    if (!e3_misneed_r) e4_mis_nxt = 17'd0;
  end

  always_ff @(posedge clk) begin
    e4_redf_r <= 50'(e3_redp_r) * 50'(e3_apos_r);
    e4_penp_r <= e3_penp_r;
    e4_mis_r  <= e4_mis_nxt;
    e4_slow_r <= e3_slow_r;
  end

  // ---------------------------------------------------------------
  // e5: penalty product
  // ---------------------------------------------------------------
  logic [49:0] e5_penf_r;
  logic [15:0] e5_red_r;
  logic        e5_slow_r;

  always_ff @(posedge clk) begin
    e5_penf_r <= 50'(e4_penp_r) * 50'(e4_mis_r);
    e5_red_r  <= e4_redf_r[47:32];
    e5_slow_r <= e4_slow_r;
  end

  // ---------------------------------------------------------------
  // e6: combine, clamp to 0..2, slow override, output registers
  // ---------------------------------------------------------------
  logic [17:0] out_scale_nxt;
  logic        out_clamp_nxt;

  always_comb begin
    logic signed [19:0] scale;
    scale = 20'sd65536 - 20'(e5_red_r) + 20'(e5_penf_r[47:32]);
    out_clamp_nxt = 1'b0;
    if (scale < 20'sd0) begin
      out_scale_nxt = '0;
      out_clamp_nxt = 1'b1;
    end else if (scale > 20'sd131072) begin
      out_scale_nxt = 18'd131072;
      out_clamp_nxt = 1'b1;
    end else begin
      out_scale_nxt = 18'(scale);
    end
    if (e5_slow_r) begin
      out_scale_nxt = UNIT_ONE;
      out_clamp_nxt = 1'b0;
    end
  end

  logic        e1_v_r, e2_v_r, e3_v_r, e4_v_r, e5_v_r, out_valid_r;
  logic [17:0] out_scale_r;
  logic        out_slow_r, out_clamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r      <= 1'b0;
      e2_v_r      <= 1'b0;
      e3_v_r      <= 1'b0;
      e4_v_r      <= 1'b0;
      e5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      e1_v_r      <= dv_v;
      e2_v_r      <= e1_v_r;
      e3_v_r      <= e2_v_r;
      e4_v_r      <= e3_v_r;
      e5_v_r      <= e4_v_r;
      out_valid_r <= e5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_scale_r <= out_scale_nxt;
    out_slow_r  <= e5_slow_r;
    out_clamp_r <= out_clamp_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_drag_mult   = out_scale_r;
  assign out_too_slow    = out_slow_r;
  assign out_was_clamped = out_clamp_r;

endmodule
`default_nettype wire

// ----- tb/sv/spin_drag_scale_tb.sv -----
// self-checking testbench for the spin drag scale block
`timescale 1ns / 1ps
`default_nettype none
module spin_drag_scale_tb import sds_pkg::*; ();

  localparam int LATENCY = 59;

  typedef struct packed {
    logic [17:0] scale;
    logic        slow;
    logic        clamped;
  } drag_res_t;

  typedef struct {
    logic [31:0] vx, vy, vz, sx, sy, sz;
    logic        known;   // expected result typed in below
    drag_res_t   want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic [31:0] in_spin_x = '0, in_spin_y = '0, in_spin_z = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [17:0] out_drag_mult;
  logic out_too_slow;
  logic out_was_clamped;

  // shadow copy of the register file
  logic [31:0] wind_q [3];
  logic [30:0] max_spin_q;
  logic [15:0] max_red_q, max_pen_q;

  drag_res_t expected_drag[$];
  int errors = 0;

  always #2 clk = ~clk;

  spin_drag_scale dut (
    .clk, .rst_n, .start, .busy,
    .in_vel_x, .in_vel_y, .in_vel_z, .in_spin_x, .in_spin_y, .in_spin_z,
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid, .out_drag_mult, .out_too_slow, .out_was_clamped
  );

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // halve until every component is below 2^30, then scale to a q.16 unit vector
  function automatic void unit_vec(input longint c[3], output longint u[3]);
    longint unsigned sq;
    longint m;
    while ((c[0] >= 2**30 || c[0] <= -(2**30)) || (c[1] >= 2**30 || c[1] <= -(2**30)) ||
           (c[2] >= 2**30 || c[2] <= -(2**30))) begin
      for (int i = 0; i < 3; i++) c[i] = c[i] / 2;
    end
    sq = 0;
    for (int i = 0; i < 3; i++) sq += longint'(c[i] * c[i]);
    m = longint'(int_sqrt(sq));
    if (m == 0) m = 1;
    for (int i = 0; i < 3; i++) u[i] = (c[i] * 65536) / m;
  endfunction

  function automatic drag_res_t drag_predict(stim_row_t s);
    longint r[3], w[3], ur[3], uw[3];
    longint unsigned vsq, wsq, wmag, thr;
    longint sf, dot, a, red, pen, mis, scale;
    logic [31:0] vin[3], sin_[3];
    bit big;
    drag_res_t res;
    vin = '{s.vx, s.vy, s.vz};
    sin_ = '{s.sx, s.sy, s.sz};
    thr = (64'd1 << 32) / 1000000;
    vsq = 0;
    wsq = 0;
    big = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'($signed(vin[i])) - longint'($signed(wind_q[i]));
      w[i] = longint'($signed(sin_[i]));
      if (r[i] >= 64'sd2147483648 || r[i] <= -64'sd2147483648) big = 1;
      wsq += longint'(w[i] * w[i]);
    end
    if (!big) for (int i = 0; i < 3; i++) vsq += longint'(r[i] * r[i]);
    if ((!big && vsq <= thr) || wsq <= thr) begin
      res.scale = 18'd65536;
      res.slow = 1'b1;
      res.clamped = 1'b0;
      return res;
    end
    wmag = int_sqrt(wsq);
    if (wmag >= max_spin_q) sf = 65536;
    else sf = longint'((wmag * 65536) / max_spin_q);
    unit_vec(r, ur);
    unit_vec(w, uw);
    dot = ur[0] * uw[0] + ur[1] * uw[1] + ur[2] * uw[2];
    a = dot / 65536;
    if (a > 65536) a = 65536;
    if (a < -65536) a = -65536;
    red = 0;
    pen = 0;
    if (a > 0) red = longint'((longint'(max_red_q) * a * sf) >>> 32);
    if (a < 32768) begin
      mis = ((32768 - a) * 2) / 3;
      pen = longint'((longint'(max_pen_q) * mis * sf) >>> 32);
    end
    scale = 65536 - red + pen;
    res.clamped = 1'b0;
    if (scale < 0) begin
      scale = 0;
      res.clamped = 1'b1;
    end
    if (scale > 131072) begin
      scale = 131072;
      res.clamped = 1'b1;
    end
    res.scale = scale[17:0];
    res.slow = 1'b0;
    return res;
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_WIND_X:        wind_q[0] = val;
      REG_WIND_Y:        wind_q[1] = val;
      REG_WIND_Z:        wind_q[2] = val;
      REG_MAX_SPIN:      max_spin_q = val[30:0];
      REG_MAX_REDUCTION: max_red_q = val[15:0];
      REG_MAX_PENALTY:   max_pen_q = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for the pipe to drain before touching registers
  task automatic drain();
    while (expected_drag.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one transaction; start stays high until the caller drops it
  task automatic send(stim_row_t s);
    drag_res_t p;
    p = drag_predict(s);
    if (s.known && p != s.want) begin
      errors++;
      $display("%0t directed row expectation %h disagrees with predictor %h",
               $time, s.want, p);
    end
    start <= 1'b1;
    in_vel_x <= s.vx; in_vel_y <= s.vy; in_vel_z <= s.vz;
    in_spin_x <= s.sx; in_spin_y <= s.sy; in_spin_z <= s.sz;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_drag.push_back(p);
  endtask

  function automatic logic [31:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      3: return 32'($signed($urandom_range(0, 131072 * 200)) - 131072 * 100);
      default: return 32'($signed($urandom_range(0, 65536 * 4000)) - 65536 * 2000);
    endcase
  endfunction

  // result checker: the receiver never stalls, so every strobe is taken
  always @(posedge clk) begin
    drag_res_t want;
    if (rst_n && out_valid) begin
      if (expected_drag.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction scale=%h", $time, out_drag_mult);
      end else begin
        want = expected_drag.pop_front();
        if (out_drag_mult !== want.scale) begin
          errors++;
          $display("%0t drag_mult exp %h got %h", $time, want.scale, out_drag_mult);
        end
        if (out_too_slow !== want.slow) begin
          errors++;
          $display("%0t too_slow exp %b got %b", $time, want.slow, out_too_slow);
        end
        if (out_was_clamped !== want.clamped) begin
          errors++;
          $display("%0t was_clamped exp %b got %b", $time, want.clamped, out_was_clamped);
        end
      end
    end
  end

  // directed table
  localparam int N_DIR = 14;
  stim_row_t dir_tab [N_DIR];

  initial begin
    stim_row_t s;
    int burst;
    int gap;
    wind_q = '{32'd0, 32'd0, 32'd0};
    max_spin_q = 31'd3276800;
    max_red_q = 16'd19661;
    max_pen_q = 16'd9830;
    // all zero: too slow
    dir_tab[0] = '{0, 0, 0, 0, 0, 0, 1'b1, '{18'd65536, 1'b1, 1'b0}};
    // speed just under threshold (4294) / spin just over
    dir_tab[1] = '{32'd65, 32'd8, 0, 32'd100, 0, 0, 1'b1, '{18'd65536, 1'b1, 1'b0}};
    dir_tab[2] = '{32'd1000, 0, 0, 32'd65, 32'd9, 0, 1'b0, '{0, 0, 0}};
    // aligned full spin: 1 - 0.30
    dir_tab[3] = '{32'h00010000, 0, 0, 32'h00640000, 0, 0, 1'b1, '{18'd45875, 1'b0, 1'b0}};
    // opposed full spin
    dir_tab[4] = '{32'h00010000, 0, 0, 32'hff9c0000, 0, 0, 1'b0, '{0, 0, 0}};
    // perpendicular
    dir_tab[5] = '{0, 32'h00050000, 0, 0, 0, 32'h00320000, 1'b0, '{0, 0, 0}};
    // extremes: huge relative velocity, huge spin
    dir_tab[6] = '{32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, '{0, 0, 0}};
    dir_tab[7] = '{32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000, 1'b0, '{0, 0, 0}};
    dir_tab[8] = '{32'hffffffff, 32'hffffffff, 32'hffffffff,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, '{0, 0, 0}};
    dir_tab[9] = '{32'h55555555, 32'haaaaaaaa, 32'h12345678,
                   32'haaaaaaaa, 32'h55555555, 32'hedcba987, 1'b0, '{0, 0, 0}};
    dir_tab[10] = '{32'h00030000, 32'h00040000, 0, 32'h00001000, 0, 0, 1'b0, '{0, 0, 0}};
    dir_tab[11] = '{32'hfffd0000, 32'h00020000, 32'h00010000,
                    32'h00020000, 32'hfffe0000, 32'h00100000, 1'b0, '{0, 0, 0}};
    dir_tab[12] = '{0, 0, 32'h00000001, 0, 0, 32'h7fffffff, 1'b0, '{0, 0, 0}};
    dir_tab[13] = '{32'h40000000, 0, 0, 32'hc0000000, 32'h00000100, 0, 1'b0, '{0, 0, 0}};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) send(dir_tab[i]);
    start <= 1'b0;
    drain();

    // register phases, extremes included; unknown index must be ignored
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_WIND_X, 32'h7fffffff); cfg_write(REG_WIND_Y, 32'h80000000);
          cfg_write(REG_WIND_Z, 32'h00030000); cfg_write(REG_MAX_SPIN, 32'd1);
          cfg_write(REG_MAX_REDUCTION, 32'hffff); cfg_write(REG_MAX_PENALTY, 32'hffff);
        end
        1: begin
          cfg_write(REG_WIND_X, 32'h80000000); cfg_write(REG_WIND_Y, 32'h7fffffff);
          cfg_write(REG_WIND_Z, 32'hfffe0000); cfg_write(REG_MAX_SPIN, 32'h7fffffff);
          cfg_write(REG_MAX_REDUCTION, 32'd0); cfg_write(REG_MAX_PENALTY, 32'd0);
        end
        2: begin
          cfg_write(REG_WIND_X, 0); cfg_write(REG_WIND_Y, 0); cfg_write(REG_WIND_Z, 0);
          cfg_write(REG_MAX_SPIN, 32'd3276800); cfg_write(REG_MAX_REDUCTION, 32'd19661);
          cfg_write(REG_MAX_PENALTY, 32'd9830);
          cfg_write(CFG_IDX_W'(6), 32'hdeadbeef); cfg_write(CFG_IDX_W'(7), 32'h0);
        end
        default: begin
          for (int k = 0; k < 3; k++)
            cfg_write(CFG_IDX_W'(k), $urandom_range(0, 1) ? $urandom()
                      : 32'($signed($urandom_range(0, 65536 * 20)) - 65536 * 10));
          cfg_write(REG_MAX_SPIN, $urandom_range(1, 32'h7fffffff) >> $urandom_range(0, 16));
          cfg_write(REG_MAX_REDUCTION, $urandom_range(0, 16'hffff));
          cfg_write(REG_MAX_PENALTY, $urandom_range(0, 16'hffff));
        end
      endcase
      // random bursts with gaps
      for (int n = 0; n < 190; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 190; b++, n++) begin
          s.vx = rnd_comp(); s.vy = rnd_comp(); s.vz = rnd_comp();
          s.sx = rnd_comp(); s.sy = rnd_comp(); s.sz = rnd_comp();
          // near the wind now and then, to hit the speed threshold
          if ($urandom_range(0, 15) == 0) begin
            s.vx = wind_q[0] + $urandom_range(0, 80) - 40;
            s.vy = wind_q[1] + $urandom_range(0, 80) - 40;
            s.vz = wind_q[2] + $urandom_range(0, 80) - 40;
          end
          s.known = 1'b0;
          s.want = '0;
          send(s);
        end
        gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 12) : 0;
        // start only drops when the sender actually pauses
        if (n == 95 || n >= 190 || gap != 0) start <= 1'b0;
        // hold off entirely when the count lands on 95, at most once per phase
        if (n == 95) while (expected_drag.size() != 0) @(posedge clk);
        else repeat (gap) @(posedge clk);
      end
      drain();
    end

    while (expected_drag.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
